// ----- rtl/core/r2dte_pkg.sv -----
`timescale 1ns / 1ps

package r2dte_pkg;

    localparam int CMD_W      = 3;
    localparam int ROT_W      = 16;
    localparam int POS_W      = 32;
    localparam int S_TDATA_W  = 192;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 224;
    localparam int SAT_IN_W   = 72;
    localparam int DOT_X_W    = POS_W + 1;
    localparam int DOT_W      = ROT_W + DOT_X_W + 1;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_COMPOSE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INVERT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POINT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TWIST   = 3'd4;

    typedef struct packed {
        logic signed [ROT_W-1:0] m00;
        logic signed [ROT_W-1:0] m01;
        logic signed [ROT_W-1:0] m10;
        logic signed [ROT_W-1:0] m11;
        logic signed [POS_W-1:0] tx;
        logic signed [POS_W-1:0] ty;
    } xform_t;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [ROT_W-1:0] rot_cos;
        logic signed [ROT_W-1:0] rot_sin;
        logic signed [POS_W-1:0] trans_x;
        logic signed [POS_W-1:0] trans_y;
        logic signed [POS_W-1:0] vec_x;
        logic signed [POS_W-1:0] vec_y;
        logic signed [POS_W-1:0] ang_rate;
    } item_t;

    function automatic logic signed [ROT_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(32767);
        lo = SAT_IN_W'(-32768);
        if (v > hi) begin
            return 16'sh7fff;
        end else if (v < lo) begin
            return 16'sh8000;
        end
        return v[ROT_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(64'sh0000_0000_7fff_ffff);
        lo = SAT_IN_W'(-64'sh0000_0000_8000_0000);
        if (v > hi) begin
            return 32'sh7fff_ffff;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[POS_W-1:0];
    endfunction

endpackage

// ----- rtl/core/rigid2d_transform_engine.sv -----
`timescale 1ns / 1ps

// Planar rigid transform engine. The block keeps one 2D homogeneous transform (rotation in
// Q2.14, translation in Q16.16) and runs one command per item: load, compose on the right,
// invert, map a point, or map a twist. It takes one item every cycle unless a stalled result
// holds the input back; each item sees the transform left by the item before it, because the
// transform register is updated in the same cycle in which an item moves from the input
// register through the multiplier array into the result register. Every result carries the
// transform as it stands after its command.
module rigid2d_transform_engine
    import r2dte_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 14,
    parameter int POS_FRAC_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // rot_cos, rot_sin, trans_x, trans_y, vec_x, vec_y, ang_rate
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // command
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // res_x, res_y, res_w, cur_m00, cur_m01, cur_m10, cur_m11, cur_tx, cur_ty
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam logic signed [ROT_W-1:0] ONE_Q =
        (ANGLE_FRAC_BITS >= ROT_W - 1) ? 16'sh7fff : ROT_W'(1 << ANGLE_FRAC_BITS);

    item_t                   item_in;
    item_t                   item_reg;
    logic                    in_valid_reg;
    logic                    out_valid_reg;
    logic [M_TDATA_W-1:0]    out_data_reg;
    xform_t                  state_reg;
    xform_t                  state_next;
    logic signed [POS_W-1:0] res_x, res_y, res_w;
    logic                    advance;

    assign item_in.command  = s_axis_tuser;
    assign item_in.rot_cos  = s_axis_tdata[15:0];
    assign item_in.rot_sin  = s_axis_tdata[31:16];
    assign item_in.trans_x  = s_axis_tdata[63:32];
    assign item_in.trans_y  = s_axis_tdata[95:64];
    assign item_in.vec_x    = s_axis_tdata[127:96];
    assign item_in.vec_y    = s_axis_tdata[159:128];
    assign item_in.ang_rate = s_axis_tdata[191:160];

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    r2dte_datapath #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .POS_FRAC_BITS  (POS_FRAC_BITS)
    ) u_datapath (
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res_x(res_x),
        .res_y(res_y),
        .res_w(res_w)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            item_reg <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            state_reg.m00 <= ONE_Q;
            state_reg.m01 <= '0;
            state_reg.m10 <= '0;
            state_reg.m11 <= ONE_Q;
            state_reg.tx  <= '0;
            state_reg.ty  <= '0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_data_reg <= {state_next.ty, state_next.tx, state_next.m11, state_next.m10,
                             state_next.m01, state_next.m00, res_w, res_y, res_x};
        end
    end

endmodule

// ----- rtl/core/r2dte_dot2.sv -----
`timescale 1ns / 1ps

module r2dte_dot2
    import r2dte_pkg::*;
(
    input  logic signed [ROT_W-1:0]   a,
    input  logic signed [ROT_W-1:0]   b,
    input  logic signed [DOT_X_W-1:0] x,
    input  logic signed [DOT_X_W-1:0] y,
    output logic signed [DOT_W-1:0]   sum
);

    logic signed [DOT_W-2:0] prod_ax;
    logic signed [DOT_W-2:0] prod_by;

    assign prod_ax = a * x;
    assign prod_by = b * y;
    assign sum     = DOT_W'(prod_ax) + DOT_W'(prod_by);

endmodule

// ----- rtl/core/r2dte_datapath.sv -----
`timescale 1ns / 1ps

module r2dte_datapath
    import r2dte_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 14,
    parameter int POS_FRAC_BITS   = 16
) (
    input  item_t                   item,
    input  xform_t                  cur,
    output xform_t                  nxt,
    output logic signed [POS_W-1:0] res_x,
    output logic signed [POS_W-1:0] res_y,
    output logic signed [POS_W-1:0] res_w
);

    logic signed [ROT_W:0]     neg_s17;
    logic signed [ROT_W-1:0]   neg_s;
    logic signed [ROT_W-1:0]   neg_m01;
    logic signed [ROT_W-1:0]   neg_m10;
    logic signed [DOT_W-1:0]   dot_r00, dot_r01, dot_r10, dot_r11;
    logic signed [ROT_W-1:0]   t0_a, t0_b, t1_a, t1_b;
    logic signed [DOT_X_W-1:0] t0_x, t0_y, t1_x, t1_y;
    logic signed [DOT_W-1:0]   dot_t0, dot_t1;
    logic signed [DOT_W-1:0]   sh_t0, sh_t1;
    logic signed [DOT_W:0]     off_t0, off_t1;
    logic signed [DOT_W:0]     inv_neg_t0;
    logic signed [2*POS_W-1:0] prod_yw, prod_xw;
    logic signed [2*POS_W:0]   neg_xw;
    logic signed [2*POS_W+1:0] twist_x, twist_y;
    logic                      is_invert;

    assign neg_s17 = -(17'(item.rot_sin));
    assign neg_s   = sat16(SAT_IN_W'(neg_s17));
    assign neg_m01 = sat16(SAT_IN_W'(-(17'(cur.m01))));
    assign neg_m10 = sat16(SAT_IN_W'(-(17'(cur.m10))));

    r2dte_dot2 u_dot_r00 (
        .a(cur.m00), .b(cur.m01), .x(DOT_X_W'(item.rot_cos)), .y(DOT_X_W'(item.rot_sin)),
        .sum(dot_r00)
    );
    r2dte_dot2 u_dot_r01 (
        .a(cur.m00), .b(cur.m01), .x(DOT_X_W'(neg_s)), .y(DOT_X_W'(item.rot_cos)),
        .sum(dot_r01)
    );
    r2dte_dot2 u_dot_r10 (
        .a(cur.m10), .b(cur.m11), .x(DOT_X_W'(item.rot_cos)), .y(DOT_X_W'(item.rot_sin)),
        .sum(dot_r10)
    );
    r2dte_dot2 u_dot_r11 (
        .a(cur.m10), .b(cur.m11), .x(DOT_X_W'(neg_s)), .y(DOT_X_W'(item.rot_cos)),
        .sum(dot_r11)
    );

    // The two translation rows serve compose, invert, point and twist.
    assign is_invert = (item.command == CMD_INVERT);

    always_comb begin
        t0_a = cur.m00;
        t0_b = cur.m01;
        t1_a = cur.m10;
        t1_b = cur.m11;
        t0_x = DOT_X_W'(item.vec_x);
        t0_y = DOT_X_W'(item.vec_y);
        if (item.command == CMD_COMPOSE) begin
            t0_x = DOT_X_W'(item.trans_x);
            t0_y = DOT_X_W'(item.trans_y);
        end else if (is_invert) begin
            t0_b = cur.m10;
            t1_b = cur.m00;
            t0_x = DOT_X_W'(cur.tx);
            t0_y = DOT_X_W'(cur.ty);
        end
        t1_x = t0_x;
        t1_y = t0_y;
        if (is_invert) begin
            t1_y = -(DOT_X_W'(cur.ty));
        end
    end

    r2dte_dot2 u_dot_t0 (.a(t0_a), .b(t0_b), .x(t0_x), .y(t0_y), .sum(dot_t0));
    r2dte_dot2 u_dot_t1 (.a(t1_a), .b(t1_b), .x(t1_x), .y(t1_y), .sum(dot_t1));

    assign sh_t0      = dot_t0 >>> ANGLE_FRAC_BITS;
    assign sh_t1      = dot_t1 >>> ANGLE_FRAC_BITS;
    assign off_t0     = (DOT_W + 1)'(sh_t0) + (DOT_W + 1)'(cur.tx);
    assign off_t1     = (DOT_W + 1)'(sh_t1) + (DOT_W + 1)'(cur.ty);
    assign inv_neg_t0 = -((DOT_W + 1)'(dot_t0));

    assign prod_yw = cur.ty * item.ang_rate;
    assign prod_xw = cur.tx * item.ang_rate;
    assign neg_xw  = -((2 * POS_W + 1)'(prod_xw));
    assign twist_x = (2 * POS_W + 2)'(prod_yw >>> POS_FRAC_BITS) + (2 * POS_W + 2)'(sh_t0);
    assign twist_y = (2 * POS_W + 2)'(neg_xw >>> POS_FRAC_BITS) + (2 * POS_W + 2)'(sh_t1);

    always_comb begin
        nxt   = cur;
        res_x = '0;
        res_y = '0;
        res_w = '0;
        unique case (item.command)
            CMD_LOAD: begin
                nxt.m00 = item.rot_cos;
                nxt.m01 = neg_s;
                nxt.m10 = item.rot_sin;
                nxt.m11 = item.rot_cos;
                nxt.tx  = item.trans_x;
                nxt.ty  = item.trans_y;
            end
            CMD_COMPOSE: begin
                nxt.m00 = sat16(SAT_IN_W'(dot_r00 >>> ANGLE_FRAC_BITS));
                nxt.m01 = sat16(SAT_IN_W'(dot_r01 >>> ANGLE_FRAC_BITS));
                nxt.m10 = sat16(SAT_IN_W'(dot_r10 >>> ANGLE_FRAC_BITS));
                nxt.m11 = sat16(SAT_IN_W'(dot_r11 >>> ANGLE_FRAC_BITS));
                nxt.tx  = sat32(SAT_IN_W'(off_t0));
                nxt.ty  = sat32(SAT_IN_W'(off_t1));
            end
            CMD_INVERT: begin
                nxt.m01 = neg_m01;
                nxt.m10 = neg_m10;
                nxt.tx  = sat32(SAT_IN_W'(inv_neg_t0 >>> ANGLE_FRAC_BITS));
                nxt.ty  = sat32(SAT_IN_W'(sh_t1));
            end
            CMD_POINT: begin
                res_x = sat32(SAT_IN_W'(off_t0));
                res_y = sat32(SAT_IN_W'(off_t1));
            end
            CMD_TWIST: begin
                res_x = sat32(SAT_IN_W'(twist_x));
                res_y = sat32(SAT_IN_W'(twist_y));
                res_w = item.ang_rate;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ----- rtl/core/r2dte_checker.sv -----
`timescale 1ns / 1ps

module r2dte_checker
    import r2dte_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result valid dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // With the result side ready the block never stalls its input.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while result side is ready");

    // An accepted item with an empty pipeline yields a result once it has passed the input and result registers.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && m_axis_tready && !m_axis_tvalid
        |=> ##1 m_axis_tvalid)
        else $error("result missing two cycles after item");

endmodule

bind rigid2d_transform_engine r2dte_checker u_checker (.*);

// ----- dv/rigid2d_transform_engine_tb.sv -----
`timescale 1ns / 1ps

module rigid2d_transform_engine_tb;
    import r2dte_pkg::*;

    localparam int ANG_FRAC = 14;
    localparam int POS_FRAC = 16;
    localparam int RANDOM_ITEMS = 1750;
    localparam longint POS_HI = 64'sh0000_0000_7fff_ffff;
    localparam longint POS_LO = -64'sh0000_0000_8000_0000;
    localparam logic signed [ROT_W-1:0] ROT_MAX = 16'sh7fff;
    localparam logic signed [ROT_W-1:0] ROT_MIN = 16'sh8000;
    localparam logic signed [ROT_W-1:0] ROT_ONE = 16'sh4000;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fff_ffff;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [POS_W-1:0] res_x;
        logic signed [POS_W-1:0] res_y;
        logic signed [POS_W-1:0] res_w;
        logic signed [ROT_W-1:0] m00;
        logic signed [ROT_W-1:0] m01;
        logic signed [ROT_W-1:0] m10;
        logic signed [ROT_W-1:0] m11;
        logic signed [POS_W-1:0] tx;
        logic signed [POS_W-1:0] ty;
    } result_t;

    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_RUNS} ready_mode_e;

    class xform_tracker;
        logic signed [ROT_W-1:0] rot [4];
        logic signed [POS_W-1:0] pos [2];
        result_t pending_results [$];
        int mismatches;
        int results_checked;
        int cmd_seen [8];

        function new();
            rot[0] = clamp16(longint'(1) << ANG_FRAC);
            rot[1] = '0;
            rot[2] = '0;
            rot[3] = clamp16(longint'(1) << ANG_FRAC);
            pos[0] = '0;
            pos[1] = '0;
            mismatches = 0;
            results_checked = 0;
            foreach (cmd_seen[i]) cmd_seen[i] = 0;
        endfunction

        static function logic signed [ROT_W-1:0] clamp16(longint v);
            if (v > 32767) return ROT_MAX;
            if (v < -32768) return ROT_MIN;
            return v[ROT_W-1:0];
        endfunction

        static function logic signed [POS_W-1:0] clamp32(longint v);
            if (v > POS_HI) return POS_MAX;
            if (v < POS_LO) return POS_MIN;
            return v[POS_W-1:0];
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [S_TDATA_W-1:0] data);
            longint c, s, tx, ty, vx, vy, w;
            longint m00, m01, m10, m11, px, py, ns;
            result_t r;
            c = $signed(data[15:0]);
            s = $signed(data[31:16]);
            tx = $signed(data[63:32]);
            ty = $signed(data[95:64]);
            vx = $signed(data[127:96]);
            vy = $signed(data[159:128]);
            w = $signed(data[191:160]);
            m00 = rot[0];
            m01 = rot[1];
            m10 = rot[2];
            m11 = rot[3];
            px = pos[0];
            py = pos[1];
            ns = clamp16(-s);
            r.res_x = '0;
            r.res_y = '0;
            r.res_w = '0;
            cmd_seen[cmd]++;
            case (cmd)
                CMD_LOAD: begin
                    rot[0] = data[15:0];
                    rot[1] = clamp16(-s);
                    rot[2] = data[31:16];
                    rot[3] = data[15:0];
                    pos[0] = data[63:32];
                    pos[1] = data[95:64];
                end
                CMD_COMPOSE: begin
                    rot[0] = clamp16((m00 * c + m01 * s) >>> ANG_FRAC);
                    rot[1] = clamp16((m00 * ns + m01 * c) >>> ANG_FRAC);
                    rot[2] = clamp16((m10 * c + m11 * s) >>> ANG_FRAC);
                    rot[3] = clamp16((m10 * ns + m11 * c) >>> ANG_FRAC);
                    pos[0] = clamp32(((m00 * tx + m01 * ty) >>> ANG_FRAC) + px);
                    pos[1] = clamp32(((m10 * tx + m11 * ty) >>> ANG_FRAC) + py);
                end
                CMD_INVERT: begin
                    rot[1] = clamp16(-m01);
                    rot[2] = clamp16(-m10);
                    pos[0] = clamp32((-(px * m00 + py * m10)) >>> ANG_FRAC);
                    pos[1] = clamp32((-(py * m00) + px * m10) >>> ANG_FRAC);
                end
                CMD_POINT: begin
                    r.res_x = clamp32(((m00 * vx + m01 * vy) >>> ANG_FRAC) + px);
                    r.res_y = clamp32(((m10 * vx + m11 * vy) >>> ANG_FRAC) + py);
                end
                CMD_TWIST: begin
                    r.res_x = clamp32(((py * w) >>> POS_FRAC) +
                                      ((m00 * vx + m01 * vy) >>> ANG_FRAC));
                    r.res_y = clamp32(((-(px * w)) >>> POS_FRAC) +
                                      ((m10 * vx + m11 * vy) >>> ANG_FRAC));
                    r.res_w = data[191:160];
                end
                default: ;
            endcase
            r.m00 = rot[0];
            r.m01 = rot[1];
            r.m10 = rot[2];
            r.m11 = rot[3];
            r.tx = pos[0];
            r.ty = pos[1];
            pending_results.push_back(r);
        endfunction

        function void compare_field(string label, longint want, longint got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch in %s at result %0d: expected %0d, got %0d",
                             label, results_checked, want, got);
                end
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            result_t want;
            results_checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result with no item outstanding: %h", data);
                end
                return;
            end
            want = pending_results.pop_front();
            compare_field("res_x", want.res_x, $signed(data[31:0]));
            compare_field("res_y", want.res_y, $signed(data[63:32]));
            compare_field("res_w", want.res_w, $signed(data[95:64]));
            compare_field("cur_m00", want.m00, $signed(data[111:96]));
            compare_field("cur_m01", want.m01, $signed(data[127:112]));
            compare_field("cur_m10", want.m10, $signed(data[143:128]));
            compare_field("cur_m11", want.m11, $signed(data[159:144]));
            compare_field("cur_tx", want.tx, $signed(data[191:160]));
            compare_field("cur_ty", want.ty, $signed(data[223:192]));
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    xform_tracker tracker;
    int burst_left = 0;
    int items_sent = 0;
    ready_mode_e ready_mode = RDY_ALWAYS;
    int mode_left = 0;
    int run_left = 0;
    logic hold_ready = 1'b0;

    always #1 aclk = ~aclk;

    rigid2d_transform_engine u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic item_t make_item(input logic [CMD_W-1:0] cmd,
                                        input logic signed [ROT_W-1:0] c, s,
                                        input logic signed [POS_W-1:0] tx, ty, vx, vy, w);
        item_t it;
        it.command = cmd;
        it.rot_cos = c;
        it.rot_sin = s;
        it.trans_x = tx;
        it.trans_y = ty;
        it.vec_x = vx;
        it.vec_y = vy;
        it.ang_rate = w;
        return it;
    endfunction

    function automatic logic signed [ROT_W-1:0] rot_extreme();
        case ($urandom_range(0, 4))
            0: return ROT_MIN;
            1: return ROT_MAX;
            2: return ROT_ONE;
            3: return -ROT_ONE;
            default: return '0;
        endcase
    endfunction

    function automatic void random_rot(output logic signed [ROT_W-1:0] c,
                                       output logic signed [ROT_W-1:0] s);
        real ang;
        int pick;
        pick = $urandom_range(0, 9);
        ang = $urandom_range(0, 62831) / 10000.0;
        if (pick < 6) begin
            c = ROT_W'($rtoi(16384.0 * $cos(ang)));
            s = ROT_W'($rtoi(16384.0 * $sin(ang)));
        end else if (pick < 8) begin
            c = ROT_W'($urandom);
            s = ROT_W'($urandom);
        end else begin
            c = rot_extreme();
            s = rot_extreme();
        end
    endfunction

    function automatic logic signed [POS_W-1:0] random_pos();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $signed($urandom) >>> 11;
            5, 6, 7: return $urandom;
            default: begin
                case ($urandom_range(0, 4))
                    0: return POS_MIN;
                    1: return POS_MAX;
                    2: return '0;
                    3: return -1;
                    default: return 1;
                endcase
            end
        endcase
    endfunction

    function automatic item_t random_item();
        item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            it.command = CMD_LOAD;
        end else if (pick < 35) begin
            it.command = CMD_COMPOSE;
        end else if (pick < 45) begin
            it.command = CMD_INVERT;
        end else if (pick < 70) begin
            it.command = CMD_POINT;
        end else if (pick < 95) begin
            it.command = CMD_TWIST;
        end else begin
            it.command = CMD_W'($urandom_range(int'(CMD_TWIST) + 1, (1 << CMD_W) - 1));
        end
        random_rot(it.rot_cos, it.rot_sin);
        it.trans_x = random_pos();
        it.trans_y = random_pos();
        it.vec_x = random_pos();
        it.vec_y = random_pos();
        it.ang_rate = random_pos();
        return it;
    endfunction

    // The sender runs in bursts; a new burst begins after a short random gap.
    task automatic send_item(input item_t it);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.ang_rate, it.vec_y, it.vec_x, it.trans_y, it.trans_x,
                         it.rot_sin, it.rot_cos};
        s_axis_tuser <= it.command;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            tracker.note_item(s_axis_tuser, s_axis_tdata);
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            tracker.check_result(m_axis_tdata);
        end
        if (mode_left == 0) begin
            ready_mode = ready_mode_e'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (ready_mode)
            RDY_ALWAYS: m_axis_tready <= 1'b1;
            RDY_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 16);
                    hold_ready = !hold_ready;
                end
                run_left--;
                m_axis_tready <= hold_ready;
            end
        endcase
    end

    initial begin
        int undefined_seen;
        tracker = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(make_item(CMD_POINT, 0, 0, 0, 0, POS_MAX, POS_MIN, 0));
        send_item(make_item(CMD_TWIST, 0, 0, 0, 0, POS_MIN, POS_MAX, POS_MAX));
        send_item(make_item(CMD_LOAD, ROT_ONE, 0, POS_MAX, POS_MIN, 0, 0, 0));
        send_item(make_item(CMD_POINT, 0, 0, 0, 0, POS_MAX, POS_MAX, 0));
        send_item(make_item(CMD_POINT, 0, 0, 0, 0, POS_MIN, POS_MIN, 0));
        send_item(make_item(CMD_TWIST, 0, 0, 0, 0, POS_MAX, POS_MIN, POS_MIN));
        send_item(make_item(CMD_TWIST, 0, 0, 0, 0, POS_MIN, POS_MAX, POS_MAX));
        // Sine at the most negative value makes the negated entry saturate.
        send_item(make_item(CMD_LOAD, ROT_MAX, ROT_MIN, 32'sh0001_0000, -32'sh0003_8000,
                            0, 0, 0));
        send_item(make_item(CMD_COMPOSE, ROT_MIN, ROT_MAX, POS_MAX, POS_MIN, 0, 0, 0));
        send_item(make_item(CMD_INVERT, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_INVERT, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_LOAD, ROT_MIN, ROT_MIN, POS_MIN, POS_MIN, 0, 0, 0));
        send_item(make_item(CMD_INVERT, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_TWIST, 0, 0, 0, 0, POS_MIN, POS_MIN, POS_MIN));
        send_item(make_item(CMD_LOAD, ROT_ONE, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_COMPOSE, 0, ROT_ONE, 32'sh0002_0000, 32'sh0005_0000, 0, 0, 0));
        send_item(make_item(CMD_POINT, 0, 0, 0, 0, 32'sh0001_0000, -32'sh0001_0000, 0));
        send_item(make_item(CMD_TWIST, 0, 0, 0, 0, 32'sh0001_0000, 32'sh0002_0000,
                            -32'sh0000_8000));
        send_item(make_item(CMD_W'(5), ROT_MAX, ROT_MIN, POS_MAX, POS_MIN, -1, 1, POS_MAX));
        send_item(make_item(CMD_W'(6), ROT_MIN, ROT_MAX, POS_MIN, POS_MAX, 1, -1, POS_MIN));
        send_item(make_item(CMD_W'(7), -1, -1, -1, -1, -1, -1, -1));
        send_item(make_item(CMD_LOAD, 0, 0, -1, 1, 0, 0, 0));
        send_item(make_item(CMD_COMPOSE, -ROT_ONE, ROT_ONE, POS_MAX, POS_MAX, 0, 0, 0));
        send_item(make_item(CMD_POINT, 0, 0, 0, 0, POS_MAX, POS_MAX, 0));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_item(random_item());
        end
        s_axis_tvalid <= 1'b0;

        while (tracker.results_checked < items_sent) @(posedge aclk);
        repeat (10) @(posedge aclk);

        undefined_seen = tracker.cmd_seen[5] + tracker.cmd_seen[6] + tracker.cmd_seen[7];
        $display("Items: load %0d, compose %0d, invert %0d, point %0d, twist %0d, undefined %0d.",
                 tracker.cmd_seen[CMD_LOAD], tracker.cmd_seen[CMD_COMPOSE],
                 tracker.cmd_seen[CMD_INVERT], tracker.cmd_seen[CMD_POINT],
                 tracker.cmd_seen[CMD_TWIST], undefined_seen);
        $display("Compared %0d results field by field under bursty input and output stalls.",
                 tracker.results_checked);
        if (tracker.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("Mismatches found: %0d", tracker.mismatches);
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Timed out with %0d results outstanding.", tracker.pending_results.size());
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/r2dte_pkg.sv
rtl/core/r2dte_dot2.sv
rtl/core/r2dte_datapath.sv
rtl/core/rigid2d_transform_engine.sv
rtl/core/r2dte_checker.sv
dv/rigid2d_transform_engine_tb.sv
